// File: hw/rtl/wsf_pkg.sv
// shared types, constants and helper functions of the framed word serializer
`default_nettype none

package wsf_pkg;

  // input commands carried on tuser
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_WORD   = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // what the back end does with the crc while it sends an entry
  typedef enum logic [1:0] {
    OP_PLAIN = 2'd0,
    OP_SEED  = 2'd1,
    OP_FOLD  = 2'd2,
    OP_CRC   = 2'd3
  } op_e;

  // configuration register indexes
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_SEED = 1'b1;

  localparam logic MODE_HEX = 1'b0;
  localparam logic MODE_BIN = 1'b1;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned EntryBytes = 5;
  localparam int unsigned IdxW       = 3;

  localparam logic [7:0]  HDR_MARK_BYTE = 8'hC0;
  localparam logic [7:0]  HEX_SPACE     = 8'h20;
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  typedef struct packed {
    op_e                        op;
    logic [EntryBytes-1:0][7:0] bytes;
    logic [IdxW-1:0]            last_idx;
  } entry_t;

  // uppercase ascii hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] n;
    n = {4'h0, nib};
    return (nib < 4'd10) ? (8'h30 + n) : (8'h37 + n);
  endfunction

  // one byte of crc-16-ccitt, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/word_stream_framer_crc16.sv
// top level of the framed word serializer with crc-16-ccitt
//
// usage:
// - slave stream takes one command beat: tuser is the command (start, word,
//   finish), tdata holds the data word and the total word count
// - master stream gives one byte per beat, tlast on the final byte of a command
// - cfg channel writes output_mode (index 0) and crc_seed (index 1) and is always
//   ready; the user must write it only while the block is idle (not enforced)
// - binary mode: start sends a 3-byte header and loads the seed, word sends
//   two bytes and folds them into the crc, finish sends the crc high first
// - hex mode: word sends four ascii hex digits and a space, others send nothing
// - the first byte of a command passes through the job queue and then the output
//   register before its tvalid rises
// - throughput: one output byte per cycle while the receiver is ready, set by the
//   single byte serializer; a binary word is 2 bytes, a header 3, a hex word 5
// - a job queue of QueueDepth entries sits between classifier and serializer,
//   so the slave side keeps taking beats while the output register waits
// - reset clears mode, seed, crc, queue and output valid
// - a stalled receiver holds the output byte; the queue fills, then tready drops
`default_nettype none

module word_stream_framer_crc16 #(
  parameter int unsigned QueueDepth = wsf_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // command stream
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // data_word [15:0], total_words [36:16], zero [39:37]
  input  wire logic [1:0]  s_axis_tuser_i,  // cmd [1:0]
  // byte stream
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [7:0]  m_axis_tdata_o,  // out_byte [7:0]
  output      logic        m_axis_tlast_o   // last_of_run
);
  import wsf_pkg::*;

  logic        s_accept;
  logic        q_push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  entry_t      push_entry;
  entry_t      head_entry;
  logic [15:0] crc_seed;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !q_full;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  wsf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (s_accept),
    .cmd_i         (s_axis_tuser_i),
    .data_word_i   (s_axis_tdata_i[15:0]),
    .total_words_i (s_axis_tdata_i[36:16]),
    .push_o        (q_push),
    .entry_o       (push_entry),
    .crc_seed_o    (crc_seed)
  );

  wsf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (head_entry)
  );

  wsf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head_entry),
    .pop_o        (q_pop),
    .crc_seed_i   (crc_seed),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_data_o     (m_axis_tdata_o),
    .m_last_o     (m_axis_tlast_o)
  );

`ifndef NO_ASSERTIONS
  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("job pushed into a full queue");

  a_pop_needs_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("job popped from an empty queue");

  a_unused_cmd_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && (s_axis_tuser_i == CMD_NONE)) |-> !q_push)
    else $error("unused command produced a job");

  a_job_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (push_entry.last_idx < IdxW'(EntryBytes)))
    else $error("job longer than the byte buffer");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/wsf_front.sv
// front end: configuration registers and classification of input beats into byte jobs
`default_nettype none

module wsf_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic                 cfg_index_i,
  input  wire logic [15:0]          cfg_data_i,
  input  wire logic                 accept_i,
  input  wire logic [1:0]           cmd_i,
  input  wire logic [15:0]          data_word_i,
  input  wire logic [20:0]          total_words_i,
  output      logic                 push_o,
  output      wsf_pkg::entry_t      entry_o,
  output      logic [15:0]          crc_seed_o
);
  import wsf_pkg::*;

  logic        mode_q;
  logic [15:0] seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HEX;
      seed_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE: mode_q <= cfg_data_i[0];
        CFG_SEED: seed_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign crc_seed_o = seed_q;

  always_comb begin
    entry_o  = '0;
    push_o   = 1'b0;
    if (mode_q == MODE_BIN) begin
      unique case (cmd_e'(cmd_i))
        CMD_START: begin
          // header: mark bits over twice the word count
          entry_o.op       = OP_SEED;
          entry_o.bytes[0] = HDR_MARK_BYTE | {2'b00, total_words_i[20:15]};
          entry_o.bytes[1] = total_words_i[14:7];
          entry_o.bytes[2] = {total_words_i[6:0], 1'b0};
          entry_o.last_idx = IdxW'(2);
          push_o           = accept_i;
        end
        CMD_WORD: begin
          entry_o.op       = OP_FOLD;
          entry_o.bytes[0] = data_word_i[15:8];
          entry_o.bytes[1] = data_word_i[7:0];
          entry_o.last_idx = IdxW'(1);
          push_o           = accept_i;
        end
        CMD_FINISH: begin
          entry_o.op       = OP_CRC;
          entry_o.last_idx = IdxW'(1);
          push_o           = accept_i;
        end
        default: ;
      endcase
    end else if (cmd_e'(cmd_i) == CMD_WORD) begin
      entry_o.op       = OP_PLAIN;
      entry_o.bytes[0] = hex_char(data_word_i[15:12]);
      entry_o.bytes[1] = hex_char(data_word_i[11:8]);
      entry_o.bytes[2] = hex_char(data_word_i[7:4]);
      entry_o.bytes[3] = hex_char(data_word_i[3:0]);
      entry_o.bytes[4] = HEX_SPACE;
      entry_o.last_idx = IdxW'(4);
      push_o           = accept_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/wsf_queue.sv
// short job queue between front and back end
`default_nettype none

module wsf_queue #(
  parameter int unsigned Depth = wsf_pkg::QueueDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire wsf_pkg::entry_t push_entry_i,
  output      logic            full_o,
  input  wire logic            pop_i,
  output      logic            valid_o,
  output      wsf_pkg::entry_t head_o
);
  import wsf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/wsf_back.sv
// back end: byte serializer with running crc and output register
`default_nettype none

module wsf_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            head_valid_i,
  input  wire wsf_pkg::entry_t head_i,
  output      logic            pop_o,
  input  wire logic [15:0]     crc_seed_i,
  output      logic            m_valid_o,
  input  wire logic            m_ready_i,
  output      logic [7:0]      m_data_o,
  output      logic            m_last_o
);
  import wsf_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     crc_q, crc_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_data_q;
  logic            out_last_q;
  logic            load;
  logic            at_last;
  logic [7:0]      cur_byte;

  assign load    = head_valid_i && (!out_valid_q || m_ready_i);
  assign at_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && at_last;

  always_comb begin
    if (head_i.op == OP_CRC) begin
      cur_byte = (idx_q == '0) ? crc_q[15:8] : crc_q[7:0];
    end else begin
      cur_byte = head_i.bytes[idx_q];
    end
  end

  always_comb begin
    idx_d       = idx_q;
    crc_d       = crc_q;
    out_valid_d = m_ready_i ? 1'b0 : out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = at_last ? '0 : idx_q + IdxW'(1);
      unique case (head_i.op)
        OP_FOLD: crc_d = crc_byte(crc_q, cur_byte);
        OP_SEED: crc_d = at_last ? crc_seed_i : crc_q;
        default: crc_d = crc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= cur_byte;
      out_last_q <= at_last;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;

endmodule

`default_nettype wire
